[rtl/bsft_pkg.sv]
// Package: shared types and constants for the blade synchronized fire timer.
package bsft_pkg;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [CFG_INDEX_BITS-1:0] REG_SOLENOID_LAG = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LED_PULSE    = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_AIM_MODE     = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LOCKOUT      = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_RELEASE      = 3'd4;

    localparam logic [15:0] RST_SOLENOID_LAG = 16'd320;
    localparam logic [15:0] RST_LED_PULSE    = 16'd100;
    localparam logic        RST_AIM_MODE     = 1'b0;
    localparam logic [5:0]  RST_LOCKOUT      = 6'd25;
    localparam logic [5:0]  RST_RELEASE      = 6'd20;

    localparam logic [2:0] PHASE_IDLE      = 3'd0;
    localparam logic [2:0] PHASE_MEASURING = 3'd1;
    localparam logic [2:0] PHASE_ARMED     = 3'd2;
    localparam logic [2:0] PHASE_DELAY     = 3'd3;
    localparam logic [2:0] PHASE_PULSE     = 3'd4;

    typedef struct packed {
        logic [15:0] solenoid_lag_ticks;
        logic [15:0] led_pulse_ticks;
        logic        aim_mode;
        logic [5:0]  lockout_ticks;
        logic [5:0]  release_count;
    } cfg_t;

    typedef struct packed {
        logic slow_tick;
        logic fast_tick;
        logic sensor_edge;
        logic button_down;
    } in_beat_t;

    typedef struct packed {
        logic        solenoid_on;
        logic        led_on;
        logic        sensor_enabled;
        logic [2:0]  phase;
        logic        fired;
        logic        too_fast;
        logic [15:0] last_period;
    } out_beat_t;

endpackage

[rtl/bsft_if.sv]
// Interfaces: valid/ready channels for step beats and result beats.
interface bsft_in_if;
    logic                valid;
    logic                ready;
    bsft_pkg::in_beat_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface bsft_out_if;
    logic                valid;
    logic                ready;
    bsft_pkg::out_beat_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/blade_synchronized_fire_timer_top.sv]
// Top level of the blade synchronized fire timer.
// One step beat is taken per clock while step.ready is high; its result beat is
// registered into the result buffer. The step update is a single combinational
// pass over the timer state. A two-entry result buffer sits at the output, so
// step.ready drops only while two results wait on result.ready. Configuration
// writes take effect on the next cycle and belong to idle periods.
module blade_synchronized_fire_timer_top
#(
    parameter int COUNTER_BITS = 16
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [bsft_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [bsft_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
    bsft_in_if.sink                             step,
    bsft_out_if.source                          result
);

    bsft_pkg::cfg_t      cfg;
    bsft_pkg::out_beat_t step_result;
    logic                can_push;
    logic                accept;

    assign step.ready = can_push;
    assign accept     = step.valid && can_push;

    bsft_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    bsft_core #(.COUNTER_BITS(COUNTER_BITS)) u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .beat   (step.data),
        .cfg    (cfg),
        .result (step_result)
    );

    bsft_outbuf u_outbuf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (step_result),
        .can_push  (can_push),
        .result    (result)
    );

endmodule

[rtl/bsft_cfg.sv]
// Configuration register file with plain write port.
module bsft_cfg
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [bsft_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [bsft_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
    output bsft_pkg::cfg_t                      cfg
);

    bsft_pkg::cfg_t cfg_reg;
    bsft_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                bsft_pkg::REG_SOLENOID_LAG: cfg_next.solenoid_lag_ticks = cfg_wdata;
                bsft_pkg::REG_LED_PULSE:    cfg_next.led_pulse_ticks    = cfg_wdata;
                bsft_pkg::REG_AIM_MODE:     cfg_next.aim_mode           = cfg_wdata[0];
                bsft_pkg::REG_LOCKOUT:      cfg_next.lockout_ticks      = cfg_wdata[5:0];
                bsft_pkg::REG_RELEASE:      cfg_next.release_count      = cfg_wdata[5:0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.solenoid_lag_ticks <= bsft_pkg::RST_SOLENOID_LAG;
            cfg_reg.led_pulse_ticks    <= bsft_pkg::RST_LED_PULSE;
            cfg_reg.aim_mode           <= bsft_pkg::RST_AIM_MODE;
            cfg_reg.lockout_ticks      <= bsft_pkg::RST_LOCKOUT;
            cfg_reg.release_count      <= bsft_pkg::RST_RELEASE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/bsft_core.sv]
// Timer state and one-step update: slow tick, then sensor edge, then fast tick.
module bsft_core
#(
    parameter int COUNTER_BITS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  bsft_pkg::in_beat_t  beat,
    input  bsft_pkg::cfg_t      cfg,
    output bsft_pkg::out_beat_t result
);

    typedef enum logic [1:0] {
        FS_NONE  = 2'd0,
        FS_DELAY = 2'd1,
        FS_PULSE = 2'd2
    } fire_seq_t;

    localparam logic [32:0] CMAX = (33'd1 << COUNTER_BITS) - 33'd1;

    logic                    armed_mode_reg,      armed_mode_next;
    logic                    measure_step_reg,    measure_step_next;
    logic [5:0]              lockout_count_reg,   lockout_count_next;
    logic [COUNTER_BITS-1:0] tick_counter_reg,    tick_counter_next;
    logic                    counter_running_reg, counter_running_next;
    logic [COUNTER_BITS-1:0] compare_value_reg,   compare_value_next;
    fire_seq_t               fire_sequence_reg,   fire_sequence_next;
    logic                    sensor_armed_reg,    sensor_armed_next;
    logic [15:0]             period_store_reg,    period_store_next;
    logic                    led_level_reg,       led_level_next;
    logic                    solenoid_level_reg,  solenoid_level_next;
    logic                    clamp_flag_reg,      clamp_flag_next;

    logic        fired;
    logic [16:0] delay_full;
    logic [16:0] lag_ext;
    logic [32:0] delay_ext;
    logic [32:0] pulse_ext;

    always_comb
    begin
        armed_mode_next      = armed_mode_reg;
        measure_step_next    = measure_step_reg;
        lockout_count_next   = lockout_count_reg;
        tick_counter_next    = tick_counter_reg;
        counter_running_next = counter_running_reg;
        compare_value_next   = compare_value_reg;
        fire_sequence_next   = fire_sequence_reg;
        sensor_armed_next    = sensor_armed_reg;
        period_store_next    = period_store_reg;
        led_level_next       = led_level_reg;
        solenoid_level_next  = solenoid_level_reg;
        clamp_flag_next      = clamp_flag_reg;
        fired                = 1'b0;
        delay_full           = 17'd0;
        lag_ext              = {1'b0, cfg.solenoid_lag_ticks};
        delay_ext            = 33'd0;
        pulse_ext            = {17'd0, cfg.led_pulse_ticks};

        // slow service tick
        if (beat.slow_tick)
        begin
            if (lockout_count_next != 6'd0)
            begin
                lockout_count_next = lockout_count_next - 6'd1;
                if (!armed_mode_next && lockout_count_next == cfg.release_count)
                begin
                    solenoid_level_next = 1'b0;
                end
            end
            else if (beat.button_down)
            begin
                lockout_count_next = cfg.lockout_ticks;
                measure_step_next  = 1'b0;
                sensor_armed_next  = 1'b1;
            end
        end

        // blade edge
        if (beat.sensor_edge && sensor_armed_next)
        begin
            if (!armed_mode_next)
            begin
                if (!measure_step_next)
                begin
                    tick_counter_next    = '0;
                    counter_running_next = 1'b1;
                    measure_step_next    = 1'b1;
                end
                else
                begin
                    period_store_next    = (33'(tick_counter_next) > 33'h0FFFF) ?
                                           16'hFFFF : 16'(tick_counter_next);
                    armed_mode_next      = 1'b1;
                    counter_running_next = 1'b0;
                    tick_counter_next    = '0;
                    sensor_armed_next    = 1'b0;
                end
            end
            else
            begin
                delay_full = {period_store_next, 1'b0};
                if (!cfg.aim_mode)
                begin
                    delay_full = delay_full - {2'b00, period_store_next[15:1]};
                end
                sensor_armed_next = 1'b0;
                tick_counter_next = '0;
                if (delay_full < lag_ext)
                begin
                    delay_ext       = 33'd0;
                    clamp_flag_next = 1'b1;
                end
                else
                begin
                    delay_ext       = {16'd0, delay_full - lag_ext};
                    clamp_flag_next = 1'b0;
                end
                compare_value_next   = (delay_ext > CMAX) ? COUNTER_BITS'(CMAX) :
                                       COUNTER_BITS'(delay_ext);
                fire_sequence_next   = FS_DELAY;
                counter_running_next = 1'b1;
            end
        end

        // fast timer tick
        if (beat.fast_tick && counter_running_next)
        begin
            if (fire_sequence_next != FS_NONE && tick_counter_next == compare_value_next)
            begin
                led_level_next = ~led_level_next;
                if (fire_sequence_next == FS_DELAY)
                begin
                    solenoid_level_next = 1'b1;
                    tick_counter_next   = '0;
                    compare_value_next  = (pulse_ext > CMAX) ? COUNTER_BITS'(CMAX) :
                                          COUNTER_BITS'(pulse_ext);
                    fire_sequence_next  = FS_PULSE;
                    fired               = 1'b1;
                end
                else
                begin
                    counter_running_next = 1'b0;
                    fire_sequence_next   = FS_NONE;
                    armed_mode_next      = 1'b0;
                end
            end
            else
            begin
                tick_counter_next = tick_counter_next + COUNTER_BITS'(1);
            end
        end
    end

    always_comb
    begin
        result.solenoid_on    = solenoid_level_next;
        result.led_on         = led_level_next;
        result.sensor_enabled = sensor_armed_next;
        result.fired          = fired;
        result.too_fast       = clamp_flag_next;
        result.last_period    = period_store_next;
        if (fire_sequence_next == FS_DELAY)
            result.phase = bsft_pkg::PHASE_DELAY;
        else if (fire_sequence_next == FS_PULSE)
            result.phase = bsft_pkg::PHASE_PULSE;
        else if (armed_mode_next)
            result.phase = bsft_pkg::PHASE_ARMED;
        else if (counter_running_next)
            result.phase = bsft_pkg::PHASE_MEASURING;
        else
            result.phase = bsft_pkg::PHASE_IDLE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_mode_reg      <= 1'b0;
            measure_step_reg    <= 1'b0;
            lockout_count_reg   <= 6'd0;
            tick_counter_reg    <= '0;
            counter_running_reg <= 1'b0;
            compare_value_reg   <= '0;
            fire_sequence_reg   <= FS_NONE;
            sensor_armed_reg    <= 1'b0;
            period_store_reg    <= 16'd0;
            led_level_reg       <= 1'b0;
            solenoid_level_reg  <= 1'b0;
            clamp_flag_reg      <= 1'b0;
        end
        else if (accept)
        begin
            armed_mode_reg      <= armed_mode_next;
            measure_step_reg    <= measure_step_next;
            lockout_count_reg   <= lockout_count_next;
            tick_counter_reg    <= tick_counter_next;
            counter_running_reg <= counter_running_next;
            compare_value_reg   <= compare_value_next;
            fire_sequence_reg   <= fire_sequence_next;
            sensor_armed_reg    <= sensor_armed_next;
            period_store_reg    <= period_store_next;
            led_level_reg       <= led_level_next;
            solenoid_level_reg  <= solenoid_level_next;
            clamp_flag_reg      <= clamp_flag_next;
        end
    end

endmodule

[rtl/bsft_outbuf.sv]
// Two-entry result buffer: output register plus skid register.
module bsft_outbuf
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  bsft_pkg::out_beat_t push_data,
    output logic                can_push,
    bsft_out_if.source          result
);

    logic                out_valid_reg,  out_valid_next;
    logic                skid_valid_reg, skid_valid_next;
    bsft_pkg::out_beat_t out_data_reg,   out_data_next;
    bsft_pkg::out_beat_t skid_data_reg,  skid_data_next;
    logic                pop;

    assign pop      = out_valid_reg && result.ready;
    assign can_push = !skid_valid_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_data_next  = push_data;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

endmodule

[rtl/bsft_checker.sv]
// Port-level checker for the fire timer and its bind to the top level.
module bsft_checker
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input bsft_pkg::out_beat_t out_data
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    // input stalls only with results waiting
    a_ready_backlog: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("step not ready with no pending result");

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.phase <= bsft_pkg::PHASE_PULSE)
        else $error("phase out of range");

    // a shot drives the solenoid and starts the LED pulse
    a_fire_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.fired |->
            out_data.solenoid_on && out_data.phase == bsft_pkg::PHASE_PULSE)
        else $error("fired without solenoid and pulse phase");

endmodule

bind blade_synchronized_fire_timer_top bsft_checker u_bsft_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (step.valid),
    .in_ready  (step.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_data  (result.data)
);

[test/tb.sv]
// Testbench: random and directed step beats for the blade synchronized fire timer, self-checked.
class fire_timer_scoreboard;
    localparam logic [1:0] SEQ_NONE  = 2'd0;
    localparam logic [1:0] SEQ_DELAY = 2'd1;
    localparam logic [1:0] SEQ_PULSE = 2'd2;

    logic [15:0] lag_ticks;
    logic [15:0] pulse_ticks;
    logic        aim_two;
    logic [5:0]  lock_ticks;
    logic [5:0]  rel_count;

    logic        armed;
    logic        meas_second;
    logic [5:0]  lock_cnt;
    logic [15:0] ticks;
    logic        running;
    logic [15:0] cmp_val;
    logic [1:0]  fire_seq;
    logic        sense_on;
    logic [15:0] period;
    logic        led;
    logic        sol;
    logic        clamp;

    bsft_pkg::out_beat_t expected_q[$];
    int                  errors;
    int                  checked;

    function new();
        lag_ticks   = bsft_pkg::RST_SOLENOID_LAG;
        pulse_ticks = bsft_pkg::RST_LED_PULSE;
        aim_two     = bsft_pkg::RST_AIM_MODE;
        lock_ticks  = bsft_pkg::RST_LOCKOUT;
        rel_count   = bsft_pkg::RST_RELEASE;
        armed       = 1'b0;
        meas_second = 1'b0;
        lock_cnt    = '0;
        ticks       = '0;
        running     = 1'b0;
        cmp_val     = '0;
        fire_seq    = SEQ_NONE;
        sense_on    = 1'b0;
        period      = '0;
        led         = 1'b0;
        sol         = 1'b0;
        clamp       = 1'b0;
        errors      = 0;
        checked     = 0;
    endfunction

    function void set_reg(logic [bsft_pkg::CFG_INDEX_BITS-1:0] idx, logic [15:0] val);
        case (idx)
            bsft_pkg::REG_SOLENOID_LAG: lag_ticks   = val;
            bsft_pkg::REG_LED_PULSE:    pulse_ticks = val;
            bsft_pkg::REG_AIM_MODE:     aim_two     = val[0];
            bsft_pkg::REG_LOCKOUT:      lock_ticks  = val[5:0];
            bsft_pkg::REG_RELEASE:      rel_count   = val[5:0];
            default: ;
        endcase
    endfunction

    function void note_step(bsft_pkg::in_beat_t b);
        bsft_pkg::out_beat_t e;
        logic                shot;
        logic [17:0]         fire_delay;
        shot = 1'b0;
        if (b.slow_tick)
        begin
            if (lock_cnt != 6'd0)
            begin
                lock_cnt = lock_cnt - 6'd1;
                if (!armed && lock_cnt == rel_count)
                    sol = 1'b0;
            end
            else if (b.button_down)
            begin
                lock_cnt    = lock_ticks;
                meas_second = 1'b0;
                sense_on    = 1'b1;
            end
        end
        if (b.sensor_edge && sense_on)
        begin
            if (!armed)
            begin
                if (!meas_second)
                begin
                    ticks       = '0;
                    running     = 1'b1;
                    meas_second = 1'b1;
                end
                else
                begin
                    period   = ticks;
                    armed    = 1'b1;
                    running  = 1'b0;
                    ticks    = '0;
                    sense_on = 1'b0;
                end
            end
            else
            begin
                fire_delay = {1'b0, period, 1'b0};
                if (!aim_two)
                    fire_delay = fire_delay - {3'b000, period[15:1]};
                sense_on = 1'b0;
                ticks    = '0;
                if (fire_delay < {2'b00, lag_ticks})
                begin
                    fire_delay = '0;
                    clamp      = 1'b1;
                end
                else
                begin
                    fire_delay = fire_delay - {2'b00, lag_ticks};
                    clamp      = 1'b0;
                end
                if (fire_delay > 18'h0FFFF)
                    fire_delay = 18'h0FFFF;
                cmp_val  = fire_delay[15:0];
                fire_seq = SEQ_DELAY;
                running  = 1'b1;
            end
        end
        if (b.fast_tick && running)
        begin
            if (fire_seq != SEQ_NONE && ticks == cmp_val)
            begin
                led = ~led;
                if (fire_seq == SEQ_DELAY)
                begin
                    sol      = 1'b1;
                    ticks    = '0;
                    cmp_val  = pulse_ticks;
                    fire_seq = SEQ_PULSE;
                    shot     = 1'b1;
                end
                else
                begin
                    running  = 1'b0;
                    fire_seq = SEQ_NONE;
                    armed    = 1'b0;
                end
            end
            else
            begin
                ticks = ticks + 16'd1;
            end
        end
        e.solenoid_on    = sol;
        e.led_on         = led;
        e.sensor_enabled = sense_on;
        if (fire_seq == SEQ_DELAY)
            e.phase = bsft_pkg::PHASE_DELAY;
        else if (fire_seq == SEQ_PULSE)
            e.phase = bsft_pkg::PHASE_PULSE;
        else if (armed)
            e.phase = bsft_pkg::PHASE_ARMED;
        else if (running)
            e.phase = bsft_pkg::PHASE_MEASURING;
        else
            e.phase = bsft_pkg::PHASE_IDLE;
        e.fired       = shot;
        e.too_fast    = clamp;
        e.last_period = period;
        expected_q.push_back(e);
    endfunction

    task report(string msg);
        $display("mismatch at result %0d: %s", checked, msg);
        errors++;
    endtask

    task compare_field(string name, int got, int want);
        if (got != want)
            report($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task check_result(bsft_pkg::out_beat_t r);
        bsft_pkg::out_beat_t e;
        if (expected_q.size() == 0)
        begin
            report("result beat with no step pending");
            return;
        end
        e = expected_q.pop_front();
        compare_field("solenoid_on", r.solenoid_on, e.solenoid_on);
        compare_field("led_on", r.led_on, e.led_on);
        compare_field("sensor_enabled", r.sensor_enabled, e.sensor_enabled);
        compare_field("phase", r.phase, e.phase);
        compare_field("fired", r.fired, e.fired);
        compare_field("too_fast", r.too_fast, e.too_fast);
        compare_field("last_period", r.last_period, e.last_period);
        checked++;
    endtask
endclass

module tb;
    localparam int CYCLE_LIMIT = 200000;

    logic                                clk;
    logic                                rst_n;
    logic                                cfg_we;
    logic [bsft_pkg::CFG_INDEX_BITS-1:0] cfg_index;
    logic [bsft_pkg::CFG_DATA_BITS-1:0]  cfg_wdata;
    logic                                calm;
    int                                  cycles;
    int                                  hold_cnt;

    fire_timer_scoreboard sb;

    bsft_in_if  step_if();
    bsft_out_if result_if();

    blade_synchronized_fire_timer_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .step      (step_if),
        .result    (result_if)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // result side: random stall bursts until the calm part
    initial
    begin
        hold_cnt = 0;
        result_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cnt > 0 && !calm)
                hold_cnt--;
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                result_if.ready <= 1'b0;
                hold_cnt = $urandom_range(1, 16) - 1;
            end
            else
                result_if.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (step_if.valid && step_if.ready)
                sb.note_step(step_if.data);
            if (result_if.valid && result_if.ready)
                sb.check_result(result_if.data);
        end
    end

    task automatic idle_sender(int n);
        step_if.valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic send_step(bsft_pkg::in_beat_t b);
        if (!calm && $urandom_range(0, 3) == 0)
            idle_sender($urandom_range(1, 16));
        step_if.valid <= 1'b1;
        step_if.data  <= b;
        do @(posedge clk); while (!step_if.ready);
    endtask

    task automatic wait_idle();
        step_if.valid <= 1'b0;
        do @(posedge clk); while (sb.expected_q.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [bsft_pkg::CFG_INDEX_BITS-1:0] idx, logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        sb.set_reg(idx, val);
    endtask

    task automatic load_settings(logic [15:0] lag, logic [15:0] pulse, logic [15:0] aim,
                                 logic [15:0] lock, logic [15:0] rel);
        write_reg(bsft_pkg::REG_SOLENOID_LAG, lag);
        write_reg(bsft_pkg::REG_LED_PULSE, pulse);
        write_reg(bsft_pkg::REG_AIM_MODE, aim);
        write_reg(bsft_pkg::REG_LOCKOUT, lock);
        write_reg(bsft_pkg::REG_RELEASE, rel);
        cfg_we <= 1'b0;
    endtask

    // blade edges every gap_lo..gap_hi beats, button held in short stretches, some noise
    task automatic run_phase(int n, int gap_lo, int gap_hi);
        bsft_pkg::in_beat_t b;
        int                 blade_cnt;
        int                 btn_left;
        blade_cnt = gap_lo;
        btn_left  = 0;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                b = bsft_pkg::in_beat_t'(4'($urandom_range(0, 15)));
            else
            begin
                b.slow_tick = ($urandom_range(0, 3) == 0);
                b.fast_tick = ($urandom_range(0, 7) != 0);
                blade_cnt--;
                b.sensor_edge = (blade_cnt <= 0);
                if (blade_cnt <= 0)
                    blade_cnt = $urandom_range(gap_lo, gap_hi);
                if (btn_left > 0)
                    btn_left--;
                else if ($urandom_range(0, 5) == 0)
                    btn_left = $urandom_range(1, 6);
                b.button_down = (btn_left > 0);
            end
            send_step(b);
        end
    endtask

    initial
    begin
        logic [3:0] at_reset[4];
        logic [3:0] one_shot[20];
        at_reset = '{4'b0000, 4'b0010, 4'b0100, 4'b1000};
        // press, measure 4 ticks, press again, delay, fire, pulse, release
        one_shot = '{4'b0000, 4'b0010, 4'b0100, 4'b1000, 4'b1111,
                     4'b0100, 4'b0100, 4'b0100, 4'b1001, 4'b0110,
                     4'b1001, 4'b0010, 4'b0100, 4'b0100, 4'b0100,
                     4'b0100, 4'b0100, 4'b0100, 4'b0100, 4'b1000};
        sb = new();
        calm = 1'b0;
        rst_n = 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        step_if.valid <= 1'b0;
        step_if.data <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (at_reset[i])
            send_step(bsft_pkg::in_beat_t'(at_reset[i]));
        wait_idle();
        load_settings(16'd3, 16'd2, 16'd0, 16'd1, 16'd0);
        foreach (one_shot[i])
            send_step(bsft_pkg::in_beat_t'(one_shot[i]));

        wait_idle();
        load_settings(16'd2, 16'd3, 16'd0, 16'd1, 16'd0);
        run_phase(90, 6, 12);

        wait_idle();
        load_settings(16'd0, 16'd1, 16'd1, 16'd2, 16'd1);
        run_phase(90, 4, 10);

        wait_idle();
        load_settings(16'd65535, 16'd0, 16'd0, 16'd0, 16'd63);
        run_phase(70, 3, 8);

        wait_idle();
        load_settings(16'd12, 16'd65535, 16'd1, 16'd63, 16'd62);
        run_phase(40, 5, 12);

        wait_idle();
        calm = 1'b1;
        load_settings(16'd5, 16'd4, 16'd0, 16'd3, 16'd2);
        run_phase(110, 6, 14);

        wait_idle();
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
